// ----- design/wdp_pkg.sv -----
// Package: shared constants, types and helper functions of the windowed dot plot cell.
`timescale 1ns / 1ps
package wdp_pkg;

    // Sizes of the sequence stores and of the compare window
    localparam int MAX_LEN    = 4096;
    localparam int MAX_WINDOW = 32;

    // Field and register widths
    localparam int ADDR_W  = $clog2(MAX_LEN);
    localparam int POS_W   = 12;
    localparam int LEN_W   = 13;
    localparam int WIN_W   = 6;
    localparam int ALLOW_W = 5;
    localparam int SYM_W   = 8;
    localparam int CNT_W   = 6;
    localparam int SUM_W   = CNT_W + 1;

    // Configuration port
    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;

    typedef logic [POS_W-1:0]   pos_t;
    typedef logic [LEN_W-1:0]   len_t;
    typedef logic [WIN_W-1:0]   win_t;
    typedef logic [ALLOW_W-1:0] allow_t;
    typedef logic [SYM_W-1:0]   sym_t;
    typedef logic [CNT_W-1:0]   cnt_t;

    // Item operation codes
    typedef enum logic [1:0] {
        MODE_LOAD_A = 2'd0,
        MODE_LOAD_B = 2'd1,
        MODE_QUERY  = 2'd2,
        MODE_NONE   = 2'd3
    } mode_t;

    // Register indexes on the configuration port
    typedef enum logic [1:0] {
        REG_LENGTH_A  = 2'd0,
        REG_LENGTH_B  = 2'd1,
        REG_WINDOW    = 2'd2,
        REG_ALLOWANCE = 2'd3
    } reg_idx_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load_a;
        logic load_b;
        logic start;
        logic issue;
        logic publish;
    } wdp_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic cont;
    } wdp_sts_t;

    // Limit a sequence length to the store depth
    function automatic len_t clamp_len(input len_t len);
        clamp_len = (len > LEN_W'(MAX_LEN)) ? LEN_W'(MAX_LEN) : len;
    endfunction

    // Limit the window to the largest supported size
    function automatic win_t clamp_win(input win_t win);
        clamp_win = (win > WIN_W'(MAX_WINDOW)) ? WIN_W'(MAX_WINDOW) : win;
    endfunction

endpackage

// ----- design/wdp_ifs.sv -----
// Interfaces: item channel and result channel of the windowed dot plot cell.
`timescale 1ns / 1ps
interface wdp_item_if;
    logic             valid;
    logic             ready;
    wdp_pkg::mode_t   mode;
    wdp_pkg::pos_t    position_a;
    wdp_pkg::pos_t    position_b;
    wdp_pkg::sym_t    symbol;

    modport source (output valid, output mode, output position_a, output position_b,
                    output symbol, input ready);
    modport sink   (input valid, input mode, input position_a, input position_b,
                    input symbol, output ready);
endinterface

interface wdp_result_if;
    logic             valid;
    logic             ready;
    logic             dot;
    wdp_pkg::cnt_t    match_count;

    modport source (output valid, output dot, output match_count, input ready);
    modport sink   (input valid, input dot, input match_count, output ready);
endinterface

// ----- design/windowed_dot_plot_cell_core.sv -----
// Top level: configuration registers, controller and datapath of the windowed dot plot cell.
//
// Usage:
//   item channel (valid/ready) carries loads and queries. A load (mode 0 or 1) writes
//   one symbol into store A or B and is done in the cycle of its transfer; loads may
//   follow each other every cycle. A query (mode 2) compares A[x+i] with B[y+i] one pair
//   per cycle, n pairs where n is the window cut short at the end of either sequence.
//   result channel (valid/ready) carries dot and match_count, one per query; mode 3
//   items are dropped without a result.
//   The result is registered when the compares of a query end. The next item
//   is taken the cycle after the result is loaded, so no new item is taken while a
//   query runs. Each store has a single read port.
//   The result register holds a finished result while the receiver stalls; a following
//   query runs to its end and then waits until the held result is transferred.
//   Reset clears the control state and sets the registers to length_a = 0,
//   length_b = 0, window length = 9, mismatch_allowance = 2. The stores are not cleared:
//   a query must read only entries that have been loaded.
//   APB registers at byte addresses 0, 4, 8, 12; write only while the block is idle.
`timescale 1ns / 1ps
module windowed_dot_plot_cell_core
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [wdp_pkg::PADDR_W-1:0]     paddr,
    input  logic [wdp_pkg::PDATA_W-1:0]     pwdata,
    output logic [wdp_pkg::PDATA_W-1:0]     prdata,
    output logic                            pready,
    wdp_item_if.sink                        item,
    wdp_result_if.source                    result
);
    import wdp_pkg::*;

    len_t     length_a_reg;
    len_t     length_b_reg;
    win_t     window_reg;
    allow_t   allow_reg;
    reg_idx_t reg_idx;
    logic     cfg_write;
    wdp_cmd_t cmd;
    wdp_sts_t sts;

    assign pready    = 1'b1;
    assign reg_idx   = reg_idx_t'(paddr[3:2]);
    assign cfg_write = psel && penable && pwrite;

    // Register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            length_a_reg <= '0;
            length_b_reg <= '0;
            window_reg   <= WIN_W'(9);
            allow_reg    <= ALLOW_W'(2);
        end
        else if (cfg_write)
        begin
            case (reg_idx)
                REG_LENGTH_A:  length_a_reg <= pwdata[LEN_W-1:0];
                REG_LENGTH_B:  length_b_reg <= pwdata[LEN_W-1:0];
                REG_WINDOW:    window_reg   <= pwdata[WIN_W-1:0];
                REG_ALLOWANCE: allow_reg    <= pwdata[ALLOW_W-1:0];
                default:       ;
            endcase
        end
    end

    // Register reads
    always_comb
    begin
        case (reg_idx)
            REG_LENGTH_A:  prdata = PDATA_W'(length_a_reg);
            REG_LENGTH_B:  prdata = PDATA_W'(length_b_reg);
            REG_WINDOW:    prdata = PDATA_W'(window_reg);
            REG_ALLOWANCE: prdata = PDATA_W'(allow_reg);
            default:       prdata = '0;
        endcase
    end

    wdp_ctrl u_ctrl
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item.valid),
        .item_mode    (item.mode),
        .item_ready   (item.ready),
        .result_valid (result.valid),
        .result_ready (result.ready),
        .sts          (sts),
        .cmd          (cmd)
    );

    wdp_dp u_dp
    (
        .clk                (clk),
        .rst_n              (rst_n),
        .cmd                (cmd),
        .sts                (sts),
        .position_a         (item.position_a),
        .position_b         (item.position_b),
        .symbol             (item.symbol),
        .length_a           (length_a_reg),
        .length_b           (length_b_reg),
        .window_len         (window_reg),
        .mismatch_allowance (allow_reg),
        .dot                (result.dot),
        .match_count        (result.match_count)
    );

    // A query transfer makes the block busy in the next cycle
    a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (item.valid && item.ready && item.mode == MODE_QUERY) |=> !item.ready)
        else $error("item ready high right after a query transfer");

    // A load keeps the item channel open
    a_load_open: assert property (@(posedge clk) disable iff (!rst_n)
        (item.valid && item.ready && item.mode != MODE_QUERY) |=> item.ready)
        else $error("item ready dropped after a load");

    // The match count never exceeds the largest window
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> (result.match_count <= CNT_W'(MAX_WINDOW)))
        else $error("match count above the largest window");

    // A full window of matches always gives a dot
    a_full_dot: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && (result.match_count >= CNT_W'(clamp_win(window_reg))))
        |-> result.dot)
        else $error("dot clear although every pair matched");

endmodule

// ----- design/wdp_ctrl.sv -----
// Controller: state machine that sequences loads and window compares.
`timescale 1ns / 1ps
module wdp_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    input  wdp_pkg::mode_t    item_mode,
    output logic              item_ready,
    output logic              result_valid,
    input  logic              result_ready,
    input  wdp_pkg::wdp_sts_t sts,
    output wdp_pkg::wdp_cmd_t cmd
);
    import wdp_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DONE
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   accept;

    // Take items only while no query is in flight
    assign item_ready   = (state_reg == ST_IDLE);
    assign accept       = item_valid && item_ready;
    assign result_valid = out_valid_reg;

    // Decode commands
    always_comb
    begin
        cmd.load_a  = accept && (item_mode == MODE_LOAD_A);
        cmd.load_b  = accept && (item_mode == MODE_LOAD_B);
        cmd.start   = accept && (item_mode == MODE_QUERY);
        cmd.issue   = (state_reg == ST_RUN) && sts.cont;
        cmd.publish = (state_reg == ST_DONE) && (!out_valid_reg || result_ready);
    end

    // Next state and output flag
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd.start)
                    state_next = ST_RUN;
            end
            ST_RUN:
            begin
                if (!sts.cont)
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (cmd.publish)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (cmd.publish)
            out_valid_next = 1'b1;
        else if (result_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    // Hold state and the result valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ----- design/wdp_dp.sv -----
// Datapath: sequence stores, window counters, match accumulator and result register.
`timescale 1ns / 1ps
module wdp_dp
(
    input  logic              clk,
    input  logic              rst_n,
    input  wdp_pkg::wdp_cmd_t cmd,
    output wdp_pkg::wdp_sts_t sts,
    input  wdp_pkg::pos_t     position_a,
    input  wdp_pkg::pos_t     position_b,
    input  wdp_pkg::sym_t     symbol,
    input  wdp_pkg::len_t     length_a,
    input  wdp_pkg::len_t     length_b,
    input  wdp_pkg::win_t     window_len,
    input  wdp_pkg::allow_t   mismatch_allowance,
    output logic              dot,
    output wdp_pkg::cnt_t     match_count
);
    import wdp_pkg::*;

    sym_t             mem_a [MAX_LEN];
    sym_t             mem_b [MAX_LEN];
    sym_t             rd_a_reg;
    sym_t             rd_b_reg;
    logic             cmp_v_reg;
    logic [LEN_W-1:0] xa_reg;
    logic [LEN_W-1:0] yb_reg;
    cnt_t             step_reg;
    cnt_t             match_reg;
    logic             dot_reg;
    cnt_t             count_reg;
    len_t             la;
    len_t             lb;
    win_t             win;
    logic [SUM_W-1:0] score;

    // Limits in force for the current query
    assign la  = clamp_len(length_a);
    assign lb  = clamp_len(length_b);
    assign win = clamp_win(window_len);

    // Keep comparing while the window lasts and both sequences have symbols
    assign sts.cont = (step_reg < CNT_W'(win)) && (xa_reg < la) && (yb_reg < lb);

    // Store A: write on load, read one symbol per compare step
    always_ff @(posedge clk)
    begin
        if (cmd.load_a)
            mem_a[position_a[ADDR_W-1:0]] <= symbol;
        if (cmd.issue)
            rd_a_reg <= mem_a[xa_reg[ADDR_W-1:0]];
    end

    // Store B: write on load, read one symbol per compare step
    always_ff @(posedge clk)
    begin
        if (cmd.load_b)
            mem_b[position_b[ADDR_W-1:0]] <= symbol;
        if (cmd.issue)
            rd_b_reg <= mem_b[yb_reg[ADDR_W-1:0]];
    end

    // Advance positions, count steps and accumulate matches
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmp_v_reg <= 1'b0;
            xa_reg    <= '0;
            yb_reg    <= '0;
            step_reg  <= '0;
            match_reg <= '0;
        end
        else
        begin
            cmp_v_reg <= cmd.issue;
            if (cmd.start)
            begin
                xa_reg    <= {1'b0, position_a};
                yb_reg    <= {1'b0, position_b};
                step_reg  <= '0;
                match_reg <= '0;
            end
            else
            begin
                if (cmd.issue)
                begin
                    xa_reg   <= xa_reg + 1'b1;
                    yb_reg   <= yb_reg + 1'b1;
                    step_reg <= step_reg + 1'b1;
                end
                if (cmp_v_reg && (rd_a_reg == rd_b_reg))
                    match_reg <= match_reg + 1'b1;
            end
        end
    end

    // Apply the threshold against the full window
    assign score = {1'b0, match_reg} + SUM_W'(mismatch_allowance);

    // Hold the result until the next query ends
    always_ff @(posedge clk)
    begin
        if (cmd.publish)
        begin
            dot_reg   <= (score >= SUM_W'(win));
            count_reg <= match_reg;
        end
    end

    assign dot         = dot_reg;
    assign match_count = count_reg;

endmodule
